// ----- sv/rpa_pkg.sv -----
package rpa_pkg;

  localparam int unsigned Slots    = 512;
  localparam int unsigned SlotW    = $clog2(Slots);
  localparam int unsigned CountW   = SlotW + 1;
  localparam int unsigned TimeW    = 48;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned HitW     = 16;
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 96;

  typedef enum logic [2:0] {
    ST_STARTED   = 3'd0,
    ST_ENDED     = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_UNDERFLOW = 3'd4
  } status_e;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_SEARCH  = 10'b0000000010,
    S_SCMP    = 10'b0000000100,
    S_POP     = 10'b0000001000,
    S_ENDRD   = 10'b0000010000,
    S_ENDACC  = 10'b0000100000,
    S_DIV     = 10'b0001000000,
    S_WRITE   = 10'b0010000000,
    S_MEANRD  = 10'b0100000000,
    S_OUT     = 10'b1000000000
  } state_e;

endpackage

// ----- sv/region_profiler_averager_core.sv -----
// Nested region profiler with per-slot running averages.
// Input channel s_axis_*: tuser carries the opcode (0 start, 1 end); tdata holds
// region_key, hit_limit and timestamp. Output channel m_axis_*: tdata holds
// slot_index, slot_key, average_ticks and status, one result for every request.
// A start request searches the key table one slot at a time (memory read
// state, then compare state); a new slot is claimed at the end of the search
// when the key is absent and the table has room. An end request pops the
// nesting stack, reads the slot's tables, adds the elapsed ticks with
// saturation and, when the hit limit is reached, runs a restoring divider that
// retires one quotient bit per cycle. The worst-case request time is set by
// the serial key search.
// The block takes one request at a time; s_axis_tready is high only when idle.
// The result sits in an output register until the receiver takes it; a stall
// simply holds it and the block stays busy. Reset clears the state, the
// output valid flag and the slot and stack counters; table contents are
// meaningless until written and are never read before they are.
module region_profiler_averager_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // region_key[31:0], hit_limit[47:32], timestamp[95:48]
  input  logic [rpa_pkg::InDataW-1:0] s_axis_tdata,
  // opcode
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // slot_index[8:0], slot_key[40:9], average_ticks[88:41], status[91:89], zeros
  output logic [rpa_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned SW = rpa_pkg::SlotW;
  localparam int unsigned CW = rpa_pkg::CountW;
  localparam int unsigned TW = rpa_pkg::TimeW;
  localparam int unsigned KW = rpa_pkg::KeyW;
  localparam int unsigned HW = rpa_pkg::HitW;
  localparam int unsigned DW = $clog2(TW + 1);

  // Slot tables, one entry per slot.
  logic [KW-1:0] key_mem   [rpa_pkg::Slots];
  logic [HW-1:0] limit_mem [rpa_pkg::Slots];
  logic [HW-1:0] hit_mem   [rpa_pkg::Slots];
  logic [TW-1:0] start_mem [rpa_pkg::Slots];
  logic [TW-1:0] sum_mem   [rpa_pkg::Slots];
  logic [TW-1:0] mean_mem  [rpa_pkg::Slots];
  logic [SW-1:0] stack_mem [rpa_pkg::Slots];

  rpa_pkg::state_e state_q, state_d;
  logic [CW-1:0] key_count_q, depth_q;
  logic          op_q;
  logic [KW-1:0] key_q;
  logic [HW-1:0] lim_in_q;
  logic [TW-1:0] now_q;
  logic [CW-1:0] idx_q;
  logic [SW-1:0] slot_q;
  logic          created_q;

  // Registered memory read data.
  logic [KW-1:0] key_rd_q;
  logic [HW-1:0] lim_rd_q, hit_rd_q;
  logic [TW-1:0] start_rd_q, sum_rd_q, mean_rd_q;
  logic [SW-1:0] stack_rd_q;

  // Accumulate and divide.
  logic [TW-1:0] sum_q;
  logic [HW-1:0] hits_q;
  logic          do_mean_q;
  logic [TW-1:0] quo_q;
  logic [HW:0]   rem_q;
  logic [DW-1:0] dcnt_q;

  logic              out_valid_q;
  logic [SW-1:0]     o_slot_q;
  logic [KW-1:0]     o_key_q;
  logic [TW-1:0]     o_avg_q;
  rpa_pkg::status_e  o_stat_q;

  logic accept;
  assign s_axis_tready = (state_q == rpa_pkg::S_IDLE) && !out_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // The popped slot addresses the tables straight from the stack read, so the
  // accumulate step sees that slot's entries.
  logic [SW-1:0] rd_addr;
  always_comb begin
    rd_addr = slot_q;
    if (state_q == rpa_pkg::S_SEARCH) rd_addr = idx_q[SW-1:0];
    if (state_q == rpa_pkg::S_ENDRD) rd_addr = stack_rd_q;
  end

  // Memory reads, one address per cycle.
  always_ff @(posedge clk_i) begin
    key_rd_q   <= key_mem[rd_addr];
    lim_rd_q   <= limit_mem[rd_addr];
    hit_rd_q   <= hit_mem[rd_addr];
    start_rd_q <= start_mem[rd_addr];
    sum_rd_q   <= sum_mem[rd_addr];
    mean_rd_q  <= mean_mem[rd_addr];
    stack_rd_q <= stack_mem[depth_q[SW-1:0] - SW'(1)];
  end

  // Saturating accumulate.
  logic [TW-1:0] elapsed;
  logic [TW:0]   sum_ext;
  logic [HW-1:0] hits_inc;
  assign elapsed  = now_q - start_rd_q;
  assign sum_ext  = {1'b0, sum_rd_q} + {1'b0, elapsed};
  assign hits_inc = hit_rd_q + HW'(1);

  logic [HW+1:0] rem_sh;
  logic [HW+1:0] rem_diff;
  assign rem_sh   = {rem_q, quo_q[TW-1]};
  assign rem_diff = rem_sh - {2'b00, hits_q};

  logic search_done;
  assign search_done = (idx_q >= key_count_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rpa_pkg::S_IDLE: begin
        if (accept) begin
          // A start on a full stack or an end on an empty one answers at once.
          if (!s_axis_tuser && depth_q == CW'(rpa_pkg::Slots)) begin
            state_d = rpa_pkg::S_IDLE;
          end else if (s_axis_tuser && depth_q == '0) begin
            state_d = rpa_pkg::S_IDLE;
          end else begin
            state_d = s_axis_tuser ? rpa_pkg::S_POP : rpa_pkg::S_SEARCH;
          end
        end
      end
      rpa_pkg::S_SEARCH: begin
        if (search_done) begin
          state_d = (key_count_q == CW'(rpa_pkg::Slots)) ? rpa_pkg::S_IDLE : rpa_pkg::S_WRITE;
        end else begin
          state_d = rpa_pkg::S_SCMP;
        end
      end
      rpa_pkg::S_SCMP: begin
        state_d = (key_rd_q == key_q) ? rpa_pkg::S_WRITE : rpa_pkg::S_SEARCH;
      end
      rpa_pkg::S_POP:    state_d = rpa_pkg::S_ENDRD;
      rpa_pkg::S_ENDRD:  state_d = rpa_pkg::S_ENDACC;
      rpa_pkg::S_ENDACC: state_d = rpa_pkg::S_DIV;
      rpa_pkg::S_DIV: begin
        if (!do_mean_q || dcnt_q == DW'(TW)) state_d = rpa_pkg::S_WRITE;
      end
      rpa_pkg::S_WRITE:  state_d = rpa_pkg::S_MEANRD;
      rpa_pkg::S_MEANRD: state_d = rpa_pkg::S_OUT;
      rpa_pkg::S_OUT:    state_d = rpa_pkg::S_IDLE;
      default:           state_d = rpa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rpa_pkg::S_IDLE;
      key_count_q <= '0;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
      unique case (state_q)
        rpa_pkg::S_IDLE: begin
          if (accept) begin
            // Error cases answer straight away.
            if (!s_axis_tuser && depth_q == CW'(rpa_pkg::Slots)) begin
              out_valid_q <= 1'b1;
            end else if (s_axis_tuser && depth_q == '0) begin
              out_valid_q <= 1'b1;
            end
          end
        end
        rpa_pkg::S_SEARCH: begin
          if (search_done && key_count_q == CW'(rpa_pkg::Slots)) begin
            out_valid_q <= 1'b1;
          end else if (search_done) begin
            key_count_q <= key_count_q + CW'(1);
          end
        end
        rpa_pkg::S_WRITE: begin
          if (!op_q) depth_q <= depth_q + CW'(1);
        end
        rpa_pkg::S_POP: depth_q <= depth_q - CW'(1);
        rpa_pkg::S_OUT: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath and memory writes.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      rpa_pkg::S_IDLE: begin
        if (accept) begin
          op_q      <= s_axis_tuser;
          key_q     <= s_axis_tdata[KW-1:0];
          lim_in_q  <= s_axis_tdata[KW+HW-1:KW];
          now_q     <= s_axis_tdata[KW+HW+TW-1:KW+HW];
          idx_q     <= '0;
          created_q <= 1'b0;
          o_slot_q  <= '0;
          o_avg_q   <= '0;
          if (!s_axis_tuser) begin
            o_key_q  <= s_axis_tdata[KW-1:0];
            o_stat_q <= rpa_pkg::ST_OVERFLOW;
          end else begin
            o_key_q  <= '0;
            o_stat_q <= rpa_pkg::ST_UNDERFLOW;
          end
        end
      end
      rpa_pkg::S_SEARCH: begin
        if (search_done) begin
          slot_q    <= idx_q[SW-1:0];
          created_q <= 1'b1;
          o_stat_q  <= rpa_pkg::ST_TABLE_FULL;
        end
      end
      rpa_pkg::S_SCMP: begin
        if (key_rd_q == key_q) slot_q <= idx_q[SW-1:0];
        idx_q <= idx_q + CW'(1);
      end
      rpa_pkg::S_POP: ;
      rpa_pkg::S_ENDRD: slot_q <= stack_rd_q;
      rpa_pkg::S_ENDACC: begin
        sum_q     <= sum_ext[TW] ? '1 : sum_ext[TW-1:0];
        hits_q    <= hits_inc;
        do_mean_q <= (lim_rd_q != '0) && (hits_inc == lim_rd_q);
        quo_q     <= sum_ext[TW] ? '1 : sum_ext[TW-1:0];
        rem_q     <= '0;
        dcnt_q    <= '0;
      end
      rpa_pkg::S_DIV: begin
        if (do_mean_q && dcnt_q != DW'(TW)) begin
          if (!rem_diff[HW+1]) begin
            rem_q <= rem_diff[HW:0];
            quo_q <= {quo_q[TW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh[HW:0];
            quo_q <= {quo_q[TW-2:0], 1'b0};
          end
          dcnt_q <= dcnt_q + DW'(1);
        end
      end
      rpa_pkg::S_WRITE: begin
        if (!op_q) begin
          stack_mem[depth_q[SW-1:0]] <= slot_q;
          start_mem[slot_q]          <= now_q;
          if (created_q) begin
            key_mem[slot_q]   <= key_q;
            limit_mem[slot_q] <= lim_in_q;
            hit_mem[slot_q]   <= '0;
            sum_mem[slot_q]   <= '0;
            mean_mem[slot_q]  <= '0;
          end
        end else if (do_mean_q) begin
          mean_mem[slot_q] <= quo_q;
          sum_mem[slot_q]  <= '0;
          hit_mem[slot_q]  <= '0;
        end else begin
          sum_mem[slot_q] <= sum_q;
          hit_mem[slot_q] <= hits_q;
        end
      end
      rpa_pkg::S_MEANRD: ;
      rpa_pkg::S_OUT: begin
        o_slot_q <= slot_q;
        o_key_q  <= key_rd_q;
        o_avg_q  <= mean_rd_q;
        o_stat_q <= op_q ? rpa_pkg::ST_ENDED : rpa_pkg::ST_STARTED;
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, o_stat_q, o_avg_q, o_key_q, o_slot_q};

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != rpa_pkg::S_IDLE) |-> !s_axis_tready)
    else $error("ready while busy");
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= CW'(rpa_pkg::Slots))
    else $error("stack depth beyond slot count");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_count_q <= CW'(rpa_pkg::Slots))
    else $error("key count beyond slot count");
  a_out_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rpa_pkg::S_OUT) |=> out_valid_q)
    else $error("result lost");

endmodule

// ----- sim/region_profiler_averager_core_tb.sv -----
`timescale 1ns / 100ps

module region_profiler_averager_core_tb;

  localparam int unsigned Slots     = rpa_pkg::Slots;
  localparam int unsigned SlotW     = rpa_pkg::SlotW;
  localparam int unsigned KeyW      = rpa_pkg::KeyW;
  localparam int unsigned HitW      = rpa_pkg::HitW;
  localparam int unsigned TimeW     = rpa_pkg::TimeW;
  localparam int unsigned InDataW   = rpa_pkg::InDataW;
  localparam int unsigned OutDataW  = rpa_pkg::OutDataW;
  localparam int unsigned IdleLimit = 20000;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic [KeyW-1:0]  key;
    logic [TimeW-1:0] avg;
    rpa_pkg::status_e st;
  } profile_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  region_profiler_averager_core dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Profiler state as the block should hold it.
  logic [KeyW-1:0]  prof_keys   [Slots];
  logic [HitW-1:0]  prof_limits [Slots];
  logic [HitW-1:0]  prof_hits   [Slots];
  logic [TimeW-1:0] prof_starts [Slots];
  logic [TimeW-1:0] prof_sums   [Slots];
  logic [TimeW-1:0] prof_means  [Slots];
  logic [SlotW-1:0] prof_nest   [Slots];
  int unsigned      prof_slots_used = 0;
  int unsigned      prof_depth = 0;

  profile_result_t  expected_q[$];
  int unsigned      error_count = 0;
  int unsigned      burst_left = 0;
  int unsigned      hold_left = 0;
  int unsigned      idle_cycles = 0;
  logic [TimeW-1:0] tick_now = '0;
  logic [KeyW-1:0]  key_pool[24];

  function automatic profile_result_t profile_step(logic is_end, logic [KeyW-1:0] key,
                                                   logic [HitW-1:0] limit,
                                                   logic [TimeW-1:0] stamp);
    profile_result_t  res;
    int unsigned      idx;
    bit               found;
    logic [TimeW-1:0] elapsed;
    logic [TimeW-1:0] sum;
    logic [HitW-1:0]  hits;
    res = '{slot: '0, key: key, avg: '0, st: rpa_pkg::ST_STARTED};
    if (!is_end) begin
      if (prof_depth >= Slots) begin
        res.st = rpa_pkg::ST_OVERFLOW;
        return res;
      end
      found = 1'b0;
      idx = 0;
      for (int unsigned i = 0; i < prof_slots_used; i++) begin
        if (prof_keys[i] == key) begin
          idx = i;
          found = 1'b1;
          break;
        end
      end
      if (!found) begin
        if (prof_slots_used >= Slots) begin
          res.st = rpa_pkg::ST_TABLE_FULL;
          return res;
        end
        idx = prof_slots_used++;
        prof_keys[idx] = key;
        prof_limits[idx] = limit;
        prof_hits[idx] = '0;
        prof_sums[idx] = '0;
        prof_means[idx] = '0;
      end
      prof_nest[prof_depth++] = idx[SlotW-1:0];
      prof_starts[idx] = stamp;
      res.slot = idx[SlotW-1:0];
      res.avg = prof_means[idx];
      return res;
    end
    if (prof_depth == 0) begin
      res.key = '0;
      res.st = rpa_pkg::ST_UNDERFLOW;
      return res;
    end
    idx = prof_nest[--prof_depth];
    elapsed = stamp - prof_starts[idx];
    sum = prof_sums[idx];
    hits = prof_hits[idx] + 1'b1;
    // The running sum sticks at the top of the tick range.
    sum = (elapsed > TimeMax - sum) ? TimeMax : sum + elapsed;
    if (prof_limits[idx] != '0 && hits == prof_limits[idx]) begin
      prof_means[idx] = sum / hits;
      sum = '0;
      hits = '0;
    end
    prof_sums[idx] = sum;
    prof_hits[idx] = hits;
    res.slot = idx[SlotW-1:0];
    res.key = prof_keys[idx];
    res.avg = prof_means[idx];
    res.st = rpa_pkg::ST_ENDED;
    return res;
  endfunction

  // Offers one request and waits for it to be taken. Valid stays high across a
  // burst; between bursts the sender drops it for a random gap.
  task automatic send_request(logic is_end, logic [KeyW-1:0] key, logic [HitW-1:0] limit,
                              logic [TimeW-1:0] stamp);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= is_end;
    s_axis_tdata <= {stamp, limit, key};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(profile_step(is_end, key, limit, stamp));
    burst_left--;
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  // Receiver: takes turns among three stall styles (always ready, random, periodic); a long hold-off overrides it.
  int unsigned rx_cycle = 0;
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      case ((rx_cycle / 256) % 3)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= (rx_cycle % 4 == 0);
      endcase
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    profile_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: tdata %h", m_axis_tdata);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata[8:0] !== want.slot) begin
          $error("slot_index: expected %0d, got %0d", want.slot, m_axis_tdata[8:0]);
          error_count++;
        end
        if (m_axis_tdata[40:9] !== want.key) begin
          $error("slot_key: expected %h, got %h", want.key, m_axis_tdata[40:9]);
          error_count++;
        end
        if (m_axis_tdata[88:41] !== want.avg) begin
          $error("average_ticks: expected %0d, got %0d", want.avg, m_axis_tdata[88:41]);
          error_count++;
        end
        if (m_axis_tdata[91:89] !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, m_axis_tdata[91:89]);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no request or result moving.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Underflow, limit zero, wrapping and saturating sums, nesting of one slot.
  task automatic test_directed();
    send_request(1'b1, '1, '1, TimeMax);
    send_request(1'b0, '0, '0, 48'd1);
    send_request(1'b1, '1, '1, '0);
    send_request(1'b0, '0, 16'd7, 48'd5);
    send_request(1'b1, '0, '0, 48'd10);
    send_request(1'b0, '1, 16'd1, TimeMax);
    send_request(1'b1, '0, '0, 48'd99);
    send_request(1'b0, 32'hA5A5_5A5A, '1, 48'h5555_AAAA_5555);
    send_request(1'b0, 32'd1, 16'd2, 48'd100);
    send_request(1'b0, '1, 16'd3, 48'd150);
    send_request(1'b0, 32'd1, 16'd9, 48'd170);
    send_request(1'b1, '0, '0, 48'd200);
    send_request(1'b1, '0, '0, 48'd260);
    send_request(1'b1, '0, '0, 48'd300);
    send_request(1'b1, '0, '0, 48'h5555_AAAA_6000);
    send_request(1'b1, '0, '0, 48'd0);
    send_request(1'b0, 32'd1, '0, 48'd400);
    send_request(1'b1, '0, '0, 48'd411);
    stop_sending();
  endtask

  task automatic test_random(int unsigned count);
    logic [HitW-1:0] limit;
    int unsigned     pick;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        tick_now = TimeW'({$urandom, $urandom});
      end else begin
        tick_now = tick_now + $urandom_range(0, 2000);
      end
      case ($urandom_range(0, 9))
        0: limit = '0;
        1: limit = HitW'($urandom_range(0, 65535));
        default: limit = HitW'($urandom_range(1, 5));
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 4 || (prof_depth > 0 && pick < 52) || prof_depth >= 10) begin
        send_request(1'b1, $urandom, limit, tick_now);
      end else begin
        send_request(1'b0, key_pool[$urandom_range(0, 23)], limit, tick_now);
      end
    end
    while (prof_depth > 0) send_request(1'b1, $urandom, '0, tick_now + $urandom_range(0, 50));
    stop_sending();
  endtask

  // The receiver holds off while requests keep arriving, so the block backs up.
  task automatic test_backpressure();
    hold_left = 400;
    for (int unsigned n = 0; n < 6; n++) begin
      send_request(n[0], key_pool[n], 16'd2, tick_now + n * 10);
    end
    send_request(1'b1, '0, '0, tick_now + 100);
    stop_sending();
  endtask

  // Fills the nesting stack and the slot table to their ends.
  task automatic test_capacity();
    int unsigned n;
    n = 0;
    while (prof_depth < Slots) begin
      // Once the table is full, an existing region is nested to go on filling the stack.
      if (prof_slots_used < Slots) begin
        send_request(1'b0, 32'h8000_0000 | n, 16'd1, tick_now + n);
      end else begin
        send_request(1'b0, 32'h8000_0000, 16'd1, tick_now + n);
      end
      n++;
    end
    send_request(1'b0, key_pool[0], '0, tick_now);
    send_request(1'b0, 32'h7FFF_FFFF, '0, tick_now);
    send_request(1'b1, '0, '0, tick_now + 4000);
    send_request(1'b0, 32'h7FFF_FFFF, '0, tick_now);
    send_request(1'b0, key_pool[1], '0, tick_now);
    send_request(1'b1, '0, '0, tick_now + 9000);
    stop_sending();
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(250);
    test_backpressure();
    test_capacity();
    wait (expected_q.size() == 0);
    repeat (100) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
